@@ src/grmwd_pkg.sv @@
// Shared types, register indexes, face codes and sine table builders for the ray marcher.
package grmwd_pkg;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LK_SIN,
      ST_LK_COS,
      ST_LK_DIF,
      ST_MARCH,
      ST_MWAIT,
      ST_HIT,
      ST_FISH,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      FACE_EAST  = 2'd0,
      FACE_WEST  = 2'd1,
      FACE_NORTH = 2'd2,
      FACE_SOUTH = 2'd3
   } face_type;

   localparam logic [2:0] CSR_PLAYER_X     = 3'd0;
   localparam logic [2:0] CSR_PLAYER_Y     = 3'd1;
   localparam logic [2:0] CSR_PLAYER_ANGLE = 3'd2;
   localparam logic [2:0] CSR_MAP_WIDTH    = 3'd3;
   localparam logic [2:0] CSR_MAP_HEIGHT   = 3'd4;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

   // Sine magnitude on the first quadrant, Q30 Taylor series rounded to Q(fb).
   // Terms x^3 .. x^13; each divisor is (n-1)*n for the term of order n.
   function automatic longint unsigned sin_mag(input int r, input int ab, input int fb);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint          sum;
      longint unsigned m;
      x   = (longint'(r) * TWO_PI_Q30 + (64'd1 << (ab - 1))) >> ab;
      x2  = (x * x) >> 30;
      t   = x;
      sum = longint'(x);
      t   = ((t * x2) >> 30) / 64'd6;
      sum = sum - longint'(t);
      t   = ((t * x2) >> 30) / 64'd20;
      sum = sum + longint'(t);
      t   = ((t * x2) >> 30) / 64'd42;
      sum = sum - longint'(t);
      t   = ((t * x2) >> 30) / 64'd72;
      sum = sum + longint'(t);
      t   = ((t * x2) >> 30) / 64'd110;
      sum = sum - longint'(t);
      t   = ((t * x2) >> 30) / 64'd156;
      sum = sum + longint'(t);
      if (sum < 0) sum = 0;
      m = longint'(sum);
      m = (m + (64'd1 << (29 - fb))) >> (30 - fb);
      return m;
   endfunction

   // Per-step increment: magnitude / 100, rounded half up.
   function automatic longint unsigned step_mag(input int r, input int ab, input int fb);
      return (sin_mag(r, ab, fb) + 64'd50) / 64'd100;
   endfunction

endpackage

@@ src/grmwd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module grmwd_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/grid_ray_march_wall_distance.sv @@
// Fixed-step grid ray marcher: wall bit map in RAM, distance, hit point and wall face per cast.
// Sequence: a map write is taken in the idle state. A cast does sine lookups in LK_SIN, LK_COS
//   and LK_DIF after the accepting edge, then 0.01-cell steps (MARCH addresses the map RAM,
//   MWAIT tests the read bit), then HIT and FISH on a hit, then DONE; leaving the map goes from
//   MARCH straight to DONE. The result is registered from DONE once the output register is free.
// One cast at a time: no request is taken until the block is back in idle.
// Reset: synchronous; clears the control registers, then sweeps all MAP_DIM*MAP_DIM map
//   addresses (4096 by default) to zero with req_ready low. CSR writes are taken meanwhile.
module grid_ray_march_wall_distance #(
   parameter int MAP_DIM    = 64,
   parameter int ANGLE_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   // config write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [21:0] csr_data,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [5:0]  req_cell_x,
   input  logic [5:0]  req_cell_y,
   input  logic        req_cell_is_wall,
   input  logic [11:0] req_ray_angle,
   input  logic        req_skip_fisheye,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [22:0] rsp_wall_distance,
   output logic        rsp_out_of_map,
   output logic [21:0] rsp_hit_x,
   output logic [21:0] rsp_hit_y,
   output logic [1:0]  rsp_wall_face
);

   // ---------------------------------------------------------------- sizes
   localparam int DEPTH   = MAP_DIM * MAP_DIM;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int QB      = ANGLE_BITS - 2;
   localparam int QUARTER = 1 << QB;
   localparam int IDX_W   = QB + 1;                 // 0..QUARTER
   localparam int SIN_W   = FRAC_BITS + 1;
   localparam int PW_MIN  = FRAC_BITS + $clog2(MAP_DIM) + 2;
   localparam int PW      = (PW_MIN > 24) ? PW_MIN : 24;   // signed position width
   localparam int CLW     = PW - FRAC_BITS;                // signed cell width
   localparam int DW      = 32;                            // distance accumulator
   localparam int STEP    = ((1 << FRAC_BITS) + 50) / 100;
   localparam int PROD_W  = DW + SIN_W;
   localparam logic [DW-1:0]     STEP_D   = DW'(STEP);
   localparam logic [22:0]       DIST_MAX = 23'h7FFFFF;
   localparam logic [8:0]        DIM_9    = 9'(MAP_DIM);
   localparam logic [ADDR_W-1:0] DIM_A    = ADDR_W'(MAP_DIM);
   localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(DEPTH - 1);
   localparam logic [ANGLE_BITS-1:0] QUARTER_A = ANGLE_BITS'(QUARTER);
   localparam logic [IDX_W-1:0]  QUARTER_I = IDX_W'(QUARTER);
   localparam logic [PROD_W-1:0] HALF_P   = PROD_W'(1) << (FRAC_BITS - 1);

   // ---------------------------------------------------------------- sine tables
   // First-quadrant magnitude and per-step increment, built at elaboration.
   logic [SIN_W-1:0] sin_tab [QUARTER + 1];
   logic [SIN_W-1:0] inc_tab [QUARTER + 1];

   for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_tab
      assign sin_tab[gi] = SIN_W'(grmwd_pkg::sin_mag(gi, ANGLE_BITS, FRAC_BITS));
      assign inc_tab[gi] = SIN_W'(grmwd_pkg::step_mag(gi, ANGLE_BITS, FRAC_BITS));
   end

   // ---------------------------------------------------------------- registers
   grmwd_pkg::state_type state_ff, state_in;

   logic [21:0]           player_x_ff, player_y_ff;
   logic [ANGLE_BITS-1:0] player_angle_ff;
   logic [8:0]            map_w_ff, map_h_ff;      // already clamped to MAP_DIM

   logic [ANGLE_BITS-1:0] ang_ff;
   logic                  skip_ff;
   logic [IDX_W-1:0]      rom_idx;
   logic [SIN_W-1:0]      rom_mag_ff, rom_inc_ff;

   logic signed [PW-1:0]  x_ff, y_ff, dx_ff, dy_ff;
   logic signed [CLW-1:0] gx_ff, gy_ff, px_ff, py_ff;   // current and back-step cells
   logic [DW-1:0]         dist_ff;
   logic [SIN_W-1:0]      cosd_mag_ff;
   logic                  cosd_neg_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [1:0]            last_face_ff;
   logic [22:0]           res_dist_ff;
   logic                  res_oom_ff;
   logic [ADDR_W-1:0]     clr_addr_ff;

   logic                  rsp_valid_ff;
   logic [22:0]           rsp_dist_ff;
   logic                  rsp_oom_ff;
   logic [21:0]           rsp_hx_ff, rsp_hy_ff;
   logic [1:0]            rsp_face_ff;

   // ---------------------------------------------------------------- map RAM
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic              ram_wdata, ram_rdata;

   grmwd_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------- handshakes
   logic req_fire, rsp_fire, csr_fire, out_free;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;
   assign req_ready = (state_ff == grmwd_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------- table lookup
   // Angle looked up this cycle; data returns next cycle.
   logic [ANGLE_BITS-1:0] look_ang;
   logic [QB-1:0]         look_r;

   always_comb begin
      case (state_ff)
         grmwd_pkg::ST_LK_SIN: look_ang = ang_ff + QUARTER_A;                      // cos(ray)
         grmwd_pkg::ST_LK_COS: look_ang = ang_ff - player_angle_ff + QUARTER_A;    // cos(diff)
         default:              look_ang = req_ray_angle[ANGLE_BITS-1:0];           // sin(ray)
      endcase
      look_r  = look_ang[QB-1:0];
      rom_idx = look_ang[QB] ? (QUARTER_I - IDX_W'(look_r)) : IDX_W'(look_r);
   end

   always_ff @(posedge clock) begin
      rom_mag_ff <= sin_tab[rom_idx];
      rom_inc_ff <= inc_tab[rom_idx];
   end

   // Sign of the value now in the lookup register (upper half-turn is negative).
   logic [ANGLE_BITS-1:0] cos_ang, dif_ang;
   logic signed [PW-1:0]  inc_pos;
   assign cos_ang = ang_ff + QUARTER_A;
   assign dif_ang = ang_ff - player_angle_ff + QUARTER_A;
   assign inc_pos = PW'(rom_inc_ff);

   // ---------------------------------------------------------------- march step
   logic signed [PW-1:0]  nx, ny;
   logic signed [CLW-1:0] ngx, ngy;
   logic [CLW:0]          w_c, h_c;
   logic                  out_map;

   assign nx  = x_ff + dx_ff;
   assign ny  = y_ff + dy_ff;
   assign ngx = CLW'(nx >>> FRAC_BITS);   // floor, also for negative values
   assign ngy = CLW'(ny >>> FRAC_BITS);
   assign w_c = (CLW + 1)'(map_w_ff);
   assign h_c = (CLW + 1)'(map_h_ff);
   assign out_map = ngx[CLW-1] || ngy[CLW-1] ||
                    ({1'b0, ngx} >= w_c) || ({1'b0, ngy} >= h_c);

   // ---------------------------------------------------------------- face and fisheye
   logic [1:0] face_in;
   always_comb begin
      face_in = last_face_ff;
      if (px_ff <= gx_ff && py_ff == gy_ff)      face_in = grmwd_pkg::FACE_EAST;
      else if (px_ff >= gx_ff && py_ff == gy_ff) face_in = grmwd_pkg::FACE_WEST;
      else if (px_ff == gx_ff && py_ff <= gy_ff) face_in = grmwd_pkg::FACE_NORTH;
      else if (px_ff == gx_ff && py_ff >= gy_ff) face_in = grmwd_pkg::FACE_SOUTH;
   end

   logic [PROD_W-1:0] rounded;
   logic [22:0]       fish_dist, plain_dist;
   assign rounded    = (prod_ff + HALF_P) >> FRAC_BITS;
   assign fish_dist  = (cosd_neg_ff || cosd_mag_ff == '0) ? 23'd0 :
                       (rounded > PROD_W'(DIST_MAX)) ? DIST_MAX : 23'(rounded);
   assign plain_dist = (dist_ff > DW'(DIST_MAX)) ? DIST_MAX : 23'(dist_ff);

   // ---------------------------------------------------------------- next state, RAM ports
   always_comb begin
      state_in  = state_ff;
      ram_we    = 1'b0;
      ram_waddr = ADDR_W'(req_cell_y) * DIM_A + ADDR_W'(req_cell_x);
      ram_wdata = req_cell_is_wall;
      ram_raddr = ADDR_W'(ngy) * DIM_A + ADDR_W'(ngx);
      unique case (state_ff)
         grmwd_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_ff;
            ram_wdata = 1'b0;
            if (clr_addr_ff == LAST_A) state_in = grmwd_pkg::ST_IDLE;
         end
         grmwd_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_opcode == grmwd_pkg::OP_WRITE) begin
                  // cells at or beyond MAP_DIM are dropped
                  ram_we = (9'(req_cell_x) < DIM_9) && (9'(req_cell_y) < DIM_9);
               end else begin
                  state_in = grmwd_pkg::ST_LK_SIN;
               end
            end
         end
         grmwd_pkg::ST_LK_SIN: state_in = grmwd_pkg::ST_LK_COS;
         grmwd_pkg::ST_LK_COS: state_in = grmwd_pkg::ST_LK_DIF;
         grmwd_pkg::ST_LK_DIF: state_in = grmwd_pkg::ST_MARCH;
         grmwd_pkg::ST_MARCH:  state_in = out_map ? grmwd_pkg::ST_DONE : grmwd_pkg::ST_MWAIT;
         grmwd_pkg::ST_MWAIT:  state_in = ram_rdata ? grmwd_pkg::ST_HIT : grmwd_pkg::ST_MARCH;
         grmwd_pkg::ST_HIT:    state_in = grmwd_pkg::ST_FISH;
         grmwd_pkg::ST_FISH:   state_in = grmwd_pkg::ST_DONE;
         grmwd_pkg::ST_DONE:   if (out_free) state_in = grmwd_pkg::ST_IDLE;
         default:              state_in = grmwd_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= grmwd_pkg::ST_CLEAR;
         clr_addr_ff     <= '0;
         last_face_ff    <= grmwd_pkg::FACE_EAST;
         rsp_valid_ff    <= 1'b0;
         player_x_ff     <= '0;
         player_y_ff     <= '0;
         player_angle_ff <= '0;
         map_w_ff        <= (DIM_9 < 9'd64) ? DIM_9 : 9'd64;
         map_h_ff        <= (DIM_9 < 9'd64) ? DIM_9 : 9'd64;
      end else begin
         state_ff <= state_in;
         if (state_ff == grmwd_pkg::ST_CLEAR) clr_addr_ff <= clr_addr_ff + 1'b1;
         if (state_ff == grmwd_pkg::ST_HIT) last_face_ff <= face_in;

         if (csr_fire) begin
            unique case (csr_index)
               grmwd_pkg::CSR_PLAYER_X:     player_x_ff <= csr_data;
               grmwd_pkg::CSR_PLAYER_Y:     player_y_ff <= csr_data;
               grmwd_pkg::CSR_PLAYER_ANGLE: player_angle_ff <= csr_data[ANGLE_BITS-1:0];
               grmwd_pkg::CSR_MAP_WIDTH:
                  map_w_ff <= (9'(csr_data[6:0]) > DIM_9) ? DIM_9 : 9'(csr_data[6:0]);
               grmwd_pkg::CSR_MAP_HEIGHT:
                  map_h_ff <= (9'(csr_data[6:0]) > DIM_9) ? DIM_9 : 9'(csr_data[6:0]);
               default: ;
            endcase
         end

         if (state_ff == grmwd_pkg::ST_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_fire)                              rsp_valid_ff <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         grmwd_pkg::ST_IDLE: begin
            ang_ff  <= req_ray_angle[ANGLE_BITS-1:0];
            skip_ff <= req_skip_fisheye;
            x_ff    <= PW'(player_x_ff);
            y_ff    <= PW'(player_y_ff);
            gx_ff   <= CLW'(PW'(player_x_ff) >>> FRAC_BITS);
            gy_ff   <= CLW'(PW'(player_y_ff) >>> FRAC_BITS);
            dist_ff <= '0;
         end
         grmwd_pkg::ST_LK_SIN: dy_ff <= ang_ff[ANGLE_BITS-1] ? -inc_pos : inc_pos;
         grmwd_pkg::ST_LK_COS: dx_ff <= cos_ang[ANGLE_BITS-1] ? -inc_pos : inc_pos;
         grmwd_pkg::ST_LK_DIF: begin
            cosd_mag_ff <= rom_mag_ff;
            cosd_neg_ff <= dif_ang[ANGLE_BITS-1];
         end
         grmwd_pkg::ST_MARCH: begin
            if (out_map) begin
               res_oom_ff  <= 1'b1;
               res_dist_ff <= DIST_MAX;
            end else begin
               x_ff    <= nx;
               y_ff    <= ny;
               px_ff   <= gx_ff;
               py_ff   <= gy_ff;
               gx_ff   <= ngx;
               gy_ff   <= ngy;
               dist_ff <= dist_ff + STEP_D;
            end
         end
         grmwd_pkg::ST_HIT: begin
            prod_ff    <= PROD_W'(dist_ff) * PROD_W'(cosd_mag_ff);
            res_oom_ff <= 1'b0;
         end
         grmwd_pkg::ST_FISH: res_dist_ff <= skip_ff ? plain_dist : fish_dist;
         default: ;
      endcase

      if (state_ff == grmwd_pkg::ST_DONE && out_free) begin
         rsp_dist_ff <= res_dist_ff;
         rsp_oom_ff  <= res_oom_ff;
         rsp_hx_ff   <= res_oom_ff ? 22'd0 : x_ff[21:0];
         rsp_hy_ff   <= res_oom_ff ? 22'd0 : y_ff[21:0];
         rsp_face_ff <= last_face_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_wall_distance = rsp_dist_ff;
   assign rsp_out_of_map    = rsp_oom_ff;
   assign rsp_hit_x         = rsp_hx_ff;
   assign rsp_hit_y         = rsp_hy_ff;
   assign rsp_wall_face     = rsp_face_ff;

endmodule

@@ test/tb.sv @@
// Testbench for the grid ray marcher: directed and random map writes and casts, checked by a scoreboard.
`timescale 1ns / 1ps

typedef struct packed {
   logic [22:0] wall_distance;
   logic        out_of_map;
   logic [21:0] hit_x;
   logic [21:0] hit_y;
   logic [1:0]  wall_face;
} ray_result_type;

class march_scoreboard;
   localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
   localparam longint STEP_Q16 = 655;
   localparam longint DIST_SAT = 8388607;

   bit                  wall_map [4096];
   grmwd_pkg::face_type last_face;
   logic [21:0]         px, py;
   logic [11:0]         pa;
   logic [6:0]          mw, mh;
   ray_result_type      pending_rays[$];
   int                  errors;

   function new();
      foreach (wall_map[i]) wall_map[i] = 1'b0;
      last_face = grmwd_pkg::FACE_EAST;
      px = '0; py = '0; pa = '0; mw = 7'd64; mh = 7'd64;
      errors = 0;
   endfunction

   function int pending();
      return pending_rays.size();
   endfunction

   // First-quadrant sine magnitude, Q30 Taylor series
   function longint unsigned quad_sine_q30(int r);
      longint unsigned x, x2, t;
      longint          acc;
      bit              sub;
      x   = (longint'(r) * TWO_PI_Q30 + 64'd2048) >> 12;
      x2  = (x * x) >> 30;
      t   = x;
      acc = longint'(x);
      sub = 1'b1;
      for (int n = 3; n <= 13; n += 2) begin
         t = ((t * x2) >> 30) / longint'((n - 1) * n);
         acc = sub ? acc - longint'(t) : acc + longint'(t);
         sub = !sub;
      end
      if (acc < 0) acc = 0;
      return longint'(acc);
   endfunction

   function longint sine_q16(logic [11:0] a);
      longint unsigned m;
      int              r;
      r = a[0 +: 10];
      m = quad_sine_q30(a[10] ? 1024 - r : r);
      m = (m + 64'd8192) >> 14;
      return a[11] ? -longint'(m) : longint'(m);
   endfunction

   function longint cosine_q16(logic [11:0] a);
      logic [11:0] s;
      s = a + 12'd1024;
      return sine_q16(s);
   endfunction

   function longint step_of(longint c);
      longint mg;
      mg = c < 0 ? -c : c;
      mg = (mg + 50) / 100;
      return c < 0 ? -mg : mg;
   endfunction

   function void note_csr(logic [2:0] idx, logic [21:0] data);
      case (idx)
         grmwd_pkg::CSR_PLAYER_X:     px = data;
         grmwd_pkg::CSR_PLAYER_Y:     py = data;
         grmwd_pkg::CSR_PLAYER_ANGLE: pa = data[11:0];
         grmwd_pkg::CSR_MAP_WIDTH:    mw = data[6:0];
         grmwd_pkg::CSR_MAP_HEIGHT:   mh = data[6:0];
         default: ;
      endcase
   endfunction

   function void note_request(logic op, logic [5:0] cx, logic [5:0] cy, logic wall,
                              logic [11:0] ang, logic skip);
      longint         x, y, dx, dy, gx, gy, sbx, sby, prod, w, h;
      longint         travel;
      logic [11:0]    diff;
      ray_result_type r;
      if (op == grmwd_pkg::OP_WRITE) begin
         wall_map[{cy, cx}] = wall;
         return;
      end
      w = mw > 64 ? 64 : mw;
      h = mh > 64 ? 64 : mh;
      x = px; y = py;
      dx = step_of(cosine_q16(ang));
      dy = step_of(sine_q16(ang));
      travel = 0;
      forever begin
         x += dx; y += dy; travel += STEP_Q16;
         gx = x >>> 16; gy = y >>> 16;
         if (gx < 0 || gx >= w || gy < 0 || gy >= h) begin
            r.wall_distance = DIST_SAT;
            r.out_of_map = 1'b1;
            r.hit_x = '0; r.hit_y = '0;
            r.wall_face = last_face;
            pending_rays.push_back(r);
            return;
         end
         if (wall_map[gy * 64 + gx]) break;
      end
      sbx = (x - dx) >>> 16;
      sby = (y - dy) >>> 16;
      if (sbx <= gx && sby == gy)      last_face = grmwd_pkg::FACE_EAST;
      else if (sbx >= gx && sby == gy) last_face = grmwd_pkg::FACE_WEST;
      else if (sbx == gx && sby <= gy) last_face = grmwd_pkg::FACE_NORTH;
      else if (sbx == gx && sby >= gy) last_face = grmwd_pkg::FACE_SOUTH;
      if (!skip) begin
         diff = ang - pa;
         prod = travel * cosine_q16(diff);
         travel = prod <= 0 ? 0 : (prod + 32768) >>> 16;
      end
      if (travel > DIST_SAT) travel = DIST_SAT;
      r.wall_distance = travel[22:0];
      r.out_of_map = 1'b0;
      r.hit_x = x[21:0];
      r.hit_y = y[21:0];
      r.wall_face = last_face;
      pending_rays.push_back(r);
   endfunction

   function void check_result(ray_result_type got);
      ray_result_type exp_r;
      if (pending_rays.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected result transaction: %p", got);
         return;
      end
      exp_r = pending_rays.pop_front();
      if (got !== exp_r) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: dist %0d/%0d oom %0d/%0d hx %0h/%0h hy %0h/%0h face %0d/%0d",
                     exp_r.wall_distance, got.wall_distance, exp_r.out_of_map, got.out_of_map,
                     exp_r.hit_x, got.hit_x, exp_r.hit_y, got.hit_y,
                     exp_r.wall_face, got.wall_face);
      end
   endfunction
endclass

module tb;
   localparam logic [2:0] CSR_UNUSED = 3'd5;
   localparam int WATCHDOG_LIMIT = 200000;  // covers the longest cast, plus the clear pass
   localparam int PRESSURE_CYCLES = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [21:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = grmwd_pkg::OP_WRITE;
   logic [5:0]  req_cell_x = '0;
   logic [5:0]  req_cell_y = '0;
   logic        req_cell_is_wall = 1'b0;
   logic [11:0] req_ray_angle = '0;
   logic        req_skip_fisheye = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [22:0] rsp_wall_distance;
   logic        rsp_out_of_map;
   logic [21:0] rsp_hit_x;
   logic [21:0] rsp_hit_y;
   logic [1:0]  rsp_wall_face;

   march_scoreboard sb = new();
   bit  no_idle = 1'b0;       // last part of the run: no gaps on either side
   bit  hold_rsp = 1'b0;      // asks the receiver for one long hold-off
   int  quiet_cycles = 0;
   int  cur_w = 64, cur_h = 64;  // map size as last written, for aiming cell writes

   grid_ray_march_wall_distance dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Monitor: every transaction is sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.note_csr(csr_index, csr_data);
         if (req_valid && req_ready)
            sb.note_request(req_opcode, req_cell_x, req_cell_y, req_cell_is_wall,
                            req_ray_angle, req_skip_fisheye);
         if (rsp_valid && rsp_ready)
            sb.check_result({rsp_wall_distance, rsp_out_of_map, rsp_hit_x, rsp_hit_y,
                             rsp_wall_face});
         // watchdog counts cycles where no channel moves a transaction
         if ((csr_valid && csr_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("status: fail");
            $finish;
         end
      end
   end

   // Receiver: random stalls, one long hold-off on request
   initial begin
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   // Whether a random gap goes before the next transaction
   function automatic bit want_gap();
      return !no_idle && $urandom_range(0, 3) == 0;
   endfunction

   // Valid is already low here, and is dropped again after each write
   task automatic write_csr(logic [2:0] idx, logic [21:0] data);
      if (want_gap()) repeat ($urandom_range(1, 15)) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == grmwd_pkg::CSR_MAP_WIDTH)  cur_w = data[6:0] > 64 ? 64 : data[6:0];
      if (idx == grmwd_pkg::CSR_MAP_HEIGHT) cur_h = data[6:0] > 64 ? 64 : data[6:0];
      @(negedge clock);
   endtask

   task automatic send_req(logic op, logic [5:0] cx, logic [5:0] cy, logic wall,
                           logic [11:0] ang, logic skip);
      if (want_gap()) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_cell_x       <= cx;
      req_cell_y       <= cy;
      req_cell_is_wall <= wall;
      req_ray_angle    <= ang;
      req_skip_fisheye <= skip;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic put_cell(int cx, int cy, bit wall);
      send_req(grmwd_pkg::OP_WRITE, 6'(cx), 6'(cy), wall, 12'($urandom), 1'($urandom));
   endtask

   task automatic cast(int ang, bit skip);
      send_req(grmwd_pkg::OP_CAST, 6'($urandom), 6'($urandom), 1'($urandom), 12'(ang), skip);
   endtask

   // Drain: all results back, then room for a trailing map write
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_view(int x, int y, int a, int w, int h);
      write_csr(grmwd_pkg::CSR_PLAYER_X, 22'(x));
      write_csr(grmwd_pkg::CSR_PLAYER_Y, 22'(y));
      write_csr(grmwd_pkg::CSR_PLAYER_ANGLE, 22'(a));
      write_csr(grmwd_pkg::CSR_MAP_WIDTH, 22'(w));
      write_csr(grmwd_pkg::CSR_MAP_HEIGHT, 22'(h));
   endtask

   task automatic random_phase(int n_items);
      int w, h;
      if ($urandom_range(0, 5) == 0) begin
         // full-range registers; most such rays leave the map at once
         set_view($urandom_range(0, 22'h3fffff), $urandom_range(0, 22'h3fffff),
                  $urandom_range(0, 22'h3fffff), $urandom_range(0, 127),
                  $urandom_range(0, 127));
      end else begin
         w = $urandom_range(1, 8);
         h = $urandom_range(1, 8);
         set_view($urandom_range(0, w * 65536 - 1), $urandom_range(0, h * 65536 - 1),
                  $urandom_range(0, 4095), w, h);
      end
      repeat (n_items) begin
         if ($urandom_range(0, 9) < 4) begin
            if ($urandom_range(0, 4) == 0 || cur_w == 0 || cur_h == 0)
               put_cell($urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom));
            else
               put_cell($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1),
                        1'($urandom));
         end else begin
            cast($urandom_range(0, 4095), 1'($urandom));
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty default map, player at the origin: axis rays and an early exit
      cast(0, 1'b0);
      cast(2048, 1'b1);
      cast(3072, 1'b0);
      wait_idle();

      // 4x4 map, player in the middle of cell (0,0)
      set_view(22'h8000, 22'h8000, 0, 4, 4);
      put_cell(3, 0, 1'b1);
      put_cell(0, 3, 1'b1);
      put_cell(1, 1, 1'b1);
      put_cell(63, 63, 1'b1);
      put_cell(63, 0, 1'b0);
      cast(1024, 1'b0);     // north face
      cast(512, 1'b0);      // diagonal into a corner: face kept
      cast(0, 1'b1);        // east face, no fisheye
      cast(4095, 1'b0);
      cast(2048, 1'b0);     // leaves the map, face repeated
      put_cell(0, 0, 1'b1);
      cast(700, 1'b0);      // starts inside a wall
      put_cell(0, 0, 1'b0);
      wait_idle();

      // Wall behind the view direction gives a zero distance
      write_csr(grmwd_pkg::CSR_PLAYER_ANGLE, 22'd2048);
      cast(0, 1'b0);
      wait_idle();

      // Register extremes: oversized width, zero height, bad index
      set_view(22'h3fffff, 22'h3fffff, 4095, 127, 0);
      write_csr(CSR_UNUSED, 22'h3fffff);
      cast(3584, 1'b0);
      wait_idle();
      set_view(22'h10000, 22'h10000, 1024, 0, 64);
      cast(0, 1'b0);
      wait_idle();

      // Random part; the receiver holds off during the second phase
      for (int p = 0; p < 7; p++) begin
         if (p == 1) hold_rsp = 1'b1;
         if (p == 6) no_idle = 1'b1;
         random_phase(12);
      end

      while (sb.pending() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
